[hw/rtl/dst_pkg.sv]
// Shared constants for the descriptor slot table: operation kinds, status
// codes, reset values and default table size. No dependencies.
package dst_pkg;

   localparam int SLOTS_DEF = 64;

   localparam int KIND_W = 3;
   localparam int SLOT_W = 7;
   localparam int DATA_W = 32;
   localparam int STATUS_W = 2;
   localparam int RSLOT_W = 6;

   localparam logic [KIND_W-1:0] KIND_ALLOC     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CLOSE     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DUP       = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DUP2      = 3'd3;
   localparam logic [KIND_W-1:0] KIND_GET       = 3'd4;
   localparam logic [KIND_W-1:0] KIND_SWEEP     = 3'd5;
   localparam logic [KIND_W-1:0] KIND_CLOSE_ALL = 3'd6;

   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   localparam logic [DATA_W-1:0] CLOEXEC_RST = 32'h0008_0000;

   typedef logic [DATA_W-1:0] word_type;

endpackage

[hw/rtl/dst_find.sv]
// Free-slot finder: lowest free slot at or above the search hint, else the
// lowest free slot overall. One registered stage. Uses dst_pkg.
module dst_find #(
   parameter int SLOTS = dst_pkg::SLOTS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [SLOTS-1:0]           free_vec,
   input  logic [$clog2(SLOTS)-1:0]   start,
   output logic                       found,
   output logic [$clog2(SLOTS)-1:0]   found_idx
);
   import dst_pkg::*;

   localparam int IW = $clog2(SLOTS);

   logic [SLOTS-1:0] upper_mask;
   logic [SLOTS-1:0] upper_free;
   logic [SLOTS-1:0] pick;
   logic [SLOTS-1:0] lowest;
   logic [SLOTS-1:0] onehot_ff;
   logic             found_ff;
   logic [IW-1:0]    idx;

   // isolate the lowest set bit with one wide add
   assign upper_mask = {SLOTS{1'b1}} << start;
   assign upper_free = free_vec & upper_mask;
   assign pick = (upper_free != '0) ? upper_free : free_vec;
   assign lowest = pick & (~pick + {{(SLOTS-1){1'b0}}, 1'b1});

   always_ff @(posedge clock) begin
      if (reset) begin
         onehot_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         onehot_ff <= lowest;
         found_ff <= |free_vec;
      end
   end

   always_comb begin
      idx = '0;
      for (int j = 0; j < SLOTS; j++) begin
         if (onehot_ff[j]) begin
            idx = idx | IW'(j);
         end
      end
   end

   assign found = found_ff;
   assign found_idx = idx;

   assert property (@(posedge clock) disable iff (reset)
      found_ff |-> $onehot(onehot_ff))
      else $error("finder: found slot is not a single bit");

   assert property (@(posedge clock) disable iff (reset)
      !found_ff |-> (onehot_ff == '0))
      else $error("finder: slot picked from a full table");

   assert property (@(posedge clock) disable iff (reset)
      !$isunknown(onehot_ff))
      else $error("finder: pick has unknown bits");

endmodule

[hw/rtl/descriptor_slot_table.sv]
// Descriptor slot table: open bits in flops, flags and ports in one
// synchronous memory with a registered read, hint register and sequencer.
// Depends on dst_pkg and dst_find.
// Close and bad kinds go to done; get and dup2 read first; alloc searches
// and commits; dup reads, searches, commits; sweeps read each slot once.
// One item at a time; the next beat is taken once the sequencer is idle,
// while the previous result may still wait in the output register.
// Reset: slots 0-2 open (flags 0, 1, 1, null port), hint 3, mask 0x80000;
// slots 0-2 read their reset values until first written. No clearing pass.
module descriptor_slot_table #(
   parameter int SLOTS = dst_pkg::SLOTS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [dst_pkg::DATA_W-1:0]     csr_wr_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [dst_pkg::KIND_W-1:0]     req_kind,
   input  logic [dst_pkg::SLOT_W-1:0]     req_slot,
   input  logic [dst_pkg::SLOT_W-1:0]     req_target_slot,
   input  logic [dst_pkg::DATA_W-1:0]     req_new_flags,
   input  logic [dst_pkg::DATA_W-1:0]     req_new_port,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [dst_pkg::STATUS_W-1:0]   rsp_status,
   output logic [dst_pkg::RSLOT_W-1:0]    rsp_result_slot,
   output logic [dst_pkg::DATA_W-1:0]     rsp_entry_flags,
   output logic [dst_pkg::DATA_W-1:0]     rsp_entry_port
);
   import dst_pkg::*;

   localparam int IW = $clog2(SLOTS);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_READ   = 3'd1;
   localparam logic [2:0] S_SEARCH = 3'd2;
   localparam logic [2:0] S_COMMIT = 3'd3;
   localparam logic [2:0] S_SWEEP  = 3'd4;
   localparam logic [2:0] S_TAIL   = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [SLOTS-1:0]      open_ff, open_in;
   logic [IW-1:0]         hint_ff, hint_in;
   word_type              mask_ff;
   logic [2:0]            init_wr_ff, init_wr_in;
   logic [IW-1:0]         cnt_ff, cnt_in;
   logic                  swp_vld_ff, swp_vld_in;

   logic [KIND_W-1:0]     op_kind_ff, op_kind_in;
   logic [SLOT_W-1:0]     op_slot_ff, op_slot_in;
   logic [SLOT_W-1:0]     op_tgt_ff, op_tgt_in;
   logic                  src_ok_ff, src_ok_in;
   word_type              wr_flags_ff, wr_flags_in;
   word_type              wr_port_ff, wr_port_in;

   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [RSLOT_W-1:0]    res_slot_ff, res_slot_in;
   word_type              res_flags_ff, res_flags_in;
   word_type              res_port_ff, res_port_in;

   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [RSLOT_W-1:0]    rsp_slot_ff;
   word_type              rsp_flags_ff;
   word_type              rsp_port_ff;

   logic [2*DATA_W-1:0]   mem [SLOTS];
   logic [2*DATA_W-1:0]   rd_q;
   logic [IW-1:0]         rd_addr;
   logic [IW-1:0]         rd_addr_ff;
   logic                  mem_we;
   logic [IW-1:0]         mem_waddr;
   logic [2*DATA_W-1:0]   mem_wdata;

   logic                  find_found;
   logic [IW-1:0]         find_idx;

   logic [IW-1:0]         sidx;
   logic [IW-1:0]         tidx;
   logic                  req_src_ok;
   logic                  tgt_ok;
   logic                  rd_init;
   word_type              eff_flags;
   word_type              eff_port;
   logic                  out_free;
   logic                  req_accept;

   dst_find #(.SLOTS(SLOTS)) u_find (
      .clock     (clock),
      .reset     (reset),
      .free_vec  (~open_ff),
      .start     (hint_ff),
      .found     (find_found),
      .found_idx (find_idx)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign sidx = IW'(req_slot);
   assign tidx = IW'(op_tgt_ff);
   assign req_src_ok = (32'(req_slot) < SLOTS) && open_ff[sidx];
   assign tgt_ok = (32'(op_tgt_ff) < SLOTS);

   // slots 0-2 hold reset contents until their first write
   assign rd_init = (rd_addr_ff < IW'(3)) && !init_wr_ff[rd_addr_ff[1:0]];
   assign eff_flags = rd_init ? ((rd_addr_ff != '0) ? 32'd1 : 32'd0) : rd_q[2*DATA_W-1:DATA_W];
   assign eff_port = rd_init ? '0 : rd_q[DATA_W-1:0];

   assign rd_addr = (state_ff == S_IDLE) ? sidx : cnt_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_q <= mem[rd_addr];
      rd_addr_ff <= rd_addr;
   end

   always_comb begin
      state_in = state_ff;
      open_in = open_ff;
      hint_in = hint_ff;
      init_wr_in = init_wr_ff;
      cnt_in = cnt_ff;
      swp_vld_in = 1'b0;
      op_kind_in = op_kind_ff;
      op_slot_in = op_slot_ff;
      op_tgt_in = op_tgt_ff;
      src_ok_in = src_ok_ff;
      wr_flags_in = wr_flags_ff;
      wr_port_in = wr_port_ff;
      res_status_in = res_status_ff;
      res_slot_in = res_slot_ff;
      res_flags_in = res_flags_ff;
      res_port_in = res_port_ff;
      mem_we = 1'b0;
      mem_waddr = find_idx;
      mem_wdata = {wr_flags_ff, wr_port_ff};

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_kind_in = req_kind;
               op_slot_in = req_slot;
               op_tgt_in = req_target_slot;
               src_ok_in = req_src_ok;
               wr_flags_in = req_new_flags;
               wr_port_in = req_new_port;
               res_status_in = ST_OK;
               res_slot_in = '0;
               res_flags_in = '0;
               res_port_in = '0;
               cnt_in = '0;
               case (req_kind)
                  KIND_ALLOC: state_in = S_SEARCH;
                  KIND_CLOSE: begin
                     if (req_src_ok) begin
                        open_in[sidx] = 1'b0;
                        if (sidx < hint_ff) begin
                           hint_in = sidx;
                        end
                     end else begin
                        res_status_in = ST_BAD;
                     end
                     state_in = S_DONE;
                  end
                  KIND_DUP, KIND_DUP2, KIND_GET: state_in = S_READ;
                  KIND_SWEEP, KIND_CLOSE_ALL: state_in = S_SWEEP;
                  default: begin
                     res_status_in = ST_BAD;
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_READ: begin
            state_in = S_DONE;
            if (!src_ok_ff) begin
               res_status_in = ST_BAD;
            end else begin
               case (op_kind_ff)
                  KIND_GET: begin
                     res_flags_in = eff_flags;
                     res_port_in = eff_port;
                  end
                  KIND_DUP: begin
                     wr_flags_in = eff_flags & ~mask_ff;
                     wr_port_in = eff_port;
                     state_in = S_SEARCH;
                  end
                  KIND_DUP2: begin
                     if (!tgt_ok) begin
                        res_status_in = ST_BAD;
                     end else begin
                        res_slot_in = RSLOT_W'(tidx);
                        if (op_slot_ff != op_tgt_ff) begin
                           // close the target first, then overwrite it
                           if (open_ff[tidx] && (tidx < hint_ff)) begin
                              hint_in = tidx;
                           end
                           open_in[tidx] = 1'b1;
                           mem_we = 1'b1;
                           mem_waddr = tidx;
                           mem_wdata = {eff_flags & ~mask_ff, eff_port};
                           if (tidx < IW'(3)) begin
                              init_wr_in[tidx[1:0]] = 1'b1;
                           end
                        end
                     end
                  end
                  default: res_status_in = ST_BAD;
               endcase
            end
         end
         S_SEARCH: begin
            // finder registers its pick this cycle
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            state_in = S_DONE;
            if (!find_found) begin
               res_status_in = ST_FULL;
            end else begin
               open_in[find_idx] = 1'b1;
               mem_we = 1'b1;
               mem_waddr = find_idx;
               if (find_idx < IW'(3)) begin
                  init_wr_in[find_idx[1:0]] = 1'b1;
               end
               hint_in = (find_idx == IW'(SLOTS-1)) ? '0 : find_idx + IW'(1);
               res_slot_in = RSLOT_W'(find_idx);
            end
         end
         S_SWEEP, S_TAIL: begin
            if (swp_vld_ff && open_ff[rd_addr_ff] &&
                ((op_kind_ff == KIND_CLOSE_ALL) || ((eff_flags & mask_ff) != '0))) begin
               open_in[rd_addr_ff] = 1'b0;
               if (rd_addr_ff < hint_ff) begin
                  hint_in = rd_addr_ff;
               end
            end
            if (state_ff == S_SWEEP) begin
               swp_vld_in = 1'b1;
               cnt_in = cnt_ff + IW'(1);
               if (cnt_ff == IW'(SLOTS-1)) begin
                  state_in = S_TAIL;
               end
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         open_ff <= {{(SLOTS-3){1'b0}}, 3'b111};
         hint_ff <= IW'(3);
         mask_ff <= CLOEXEC_RST;
         init_wr_ff <= '0;
         swp_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         open_ff <= open_in;
         hint_ff <= hint_in;
         init_wr_ff <= init_wr_in;
         swp_vld_ff <= swp_vld_in;
         if (csr_wr_en) begin
            mask_ff <= csr_wr_data;
         end
         if (state_ff == S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      op_kind_ff <= op_kind_in;
      op_slot_ff <= op_slot_in;
      op_tgt_ff <= op_tgt_in;
      src_ok_ff <= src_ok_in;
      wr_flags_ff <= wr_flags_in;
      wr_port_ff <= wr_port_in;
      res_status_ff <= res_status_in;
      res_slot_ff <= res_slot_in;
      res_flags_ff <= res_flags_in;
      res_port_ff <= res_port_in;
      // load the output beat only when the previous one is gone
      if (state_ff == S_DONE && out_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff <= res_slot_ff;
         rsp_flags_ff <= res_flags_ff;
         rsp_port_ff <= res_port_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_result_slot = rsp_slot_ff;
   assign rsp_entry_flags = rsp_flags_ff;
   assign rsp_entry_port = rsp_port_ff;

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("result beat raised outside the done step");

   assert property (@(posedge clock) disable iff (reset)
      32'(hint_ff) < SLOTS)
      else $error("search hint beyond the table");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMMIT && find_found) |=> open_ff[$past(find_idx)])
      else $error("allocated slot not marked open");

endmodule

[verif/descriptor_slot_table_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for descriptor_slot_table: directed and random table
// operations against an in-bench model of the slot table. Depends on dst_pkg.
module descriptor_slot_table_test;
   import dst_pkg::*;

   localparam int N_SLOTS = SLOTS_DEF;
   localparam int SETTLE_CYCLES = N_SLOTS + 8;
   localparam int MAX_PRINTS = 100;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [RSLOT_W-1:0]  result_slot;
      word_type            entry_flags;
      word_type            entry_port;
   } outcome_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [DATA_W-1:0]   csr_wr_data = '0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [KIND_W-1:0]   req_kind = '0;
   logic [SLOT_W-1:0]   req_slot = '0;
   logic [SLOT_W-1:0]   req_target_slot = '0;
   logic [DATA_W-1:0]   req_new_flags = '0;
   logic [DATA_W-1:0]   req_new_port = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [RSLOT_W-1:0]  rsp_result_slot;
   logic [DATA_W-1:0]   rsp_entry_flags;
   logic [DATA_W-1:0]   rsp_entry_port;

   // table model
   bit       open_model [N_SLOTS];
   word_type flags_model [N_SLOTS];
   word_type ports_model [N_SLOTS];
   int       hint_model;
   word_type cloexec_model;

   outcome_type expected_outcomes[$];
   int       mismatch_count = 0;
   int       stall_left = 0;
   bit       valid_held = 1'b0;
   bit       quiet = 1'b0;

   descriptor_slot_table #(.SLOTS(N_SLOTS)) dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_slot        (req_slot),
      .req_target_slot (req_target_slot),
      .req_new_flags   (req_new_flags),
      .req_new_port    (req_new_port),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_result_slot (rsp_result_slot),
      .rsp_entry_flags (rsp_entry_flags),
      .rsp_entry_port  (rsp_entry_port)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void release_slot(input int s);
      open_model[s] = 1'b0;
      flags_model[s] = '0;
      ports_model[s] = '0;
      if (s < hint_model) hint_model = s;
   endfunction

   // Returns N_SLOTS when nothing is free.
   function automatic int claim_free_slot(input word_type flags, input word_type port);
      int first, found, i;
      first = (hint_model < N_SLOTS) ? hint_model : 0;
      found = N_SLOTS;
      for (i = first; i < N_SLOTS && found == N_SLOTS; i++)
         if (!open_model[i]) found = i;
      for (i = 0; i < first && found == N_SLOTS; i++)
         if (!open_model[i]) found = i;
      if (found == N_SLOTS) return N_SLOTS;
      open_model[found] = 1'b1;
      flags_model[found] = flags;
      ports_model[found] = port;
      hint_model = (found + 1 < N_SLOTS) ? found + 1 : 0;
      return found;
   endfunction

   function automatic outcome_type table_step(input logic [KIND_W-1:0] kind,
                                              input logic [SLOT_W-1:0] src,
                                              input logic [SLOT_W-1:0] dst,
                                              input word_type nflags,
                                              input word_type nport);
      outcome_type o;
      int n, i, si, di;
      bit src_ok;
      o = '0;
      si = int'(src);
      di = int'(dst);
      src_ok = 1'b0;
      if (si < N_SLOTS) src_ok = open_model[si];
      case (kind)
         KIND_ALLOC: begin
            n = claim_free_slot(nflags, nport);
            if (n == N_SLOTS) o.status = ST_FULL;
            else o.result_slot = n[RSLOT_W-1:0];
         end
         KIND_CLOSE: begin
            if (!src_ok) o.status = ST_BAD;
            else release_slot(si);
         end
         KIND_DUP: begin
            if (!src_ok) begin
               o.status = ST_BAD;
            end else begin
               n = claim_free_slot(flags_model[si] & ~cloexec_model, ports_model[si]);
               if (n == N_SLOTS) o.status = ST_FULL;
               else o.result_slot = n[RSLOT_W-1:0];
            end
         end
         KIND_DUP2: begin
            if (!src_ok || di >= N_SLOTS) begin
               o.status = ST_BAD;
            end else if (si == di) begin
               o.result_slot = dst[RSLOT_W-1:0];
            end else begin
               // close an open target first; that may pull the hint down
               if (open_model[di]) release_slot(di);
               open_model[di] = 1'b1;
               flags_model[di] = flags_model[si] & ~cloexec_model;
               ports_model[di] = ports_model[si];
               o.result_slot = dst[RSLOT_W-1:0];
            end
         end
         KIND_GET: begin
            if (!src_ok) begin
               o.status = ST_BAD;
            end else begin
               o.entry_flags = flags_model[si];
               o.entry_port = ports_model[si];
            end
         end
         KIND_SWEEP: begin
            for (i = 0; i < N_SLOTS; i++)
               if (open_model[i] && (flags_model[i] & cloexec_model) != '0) release_slot(i);
         end
         KIND_CLOSE_ALL: begin
            for (i = 0; i < N_SLOTS; i++)
               if (open_model[i]) release_slot(i);
         end
         default: o.status = ST_BAD;
      endcase
      return o;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTS)
         $display("%0t: mismatch in %s: got %h, want %h", $time, field, got, want);
   endtask

   // Check each result beat, then draw the stall ahead of the next one.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_outcomes.size() == 0) begin
               report_mismatch("result with none pending", 32'(rsp_status), '0);
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", 32'(rsp_status), 32'(want.status));
               if (rsp_result_slot !== want.result_slot)
                  report_mismatch("result_slot", 32'(rsp_result_slot),
                                  32'(want.result_slot));
               if (rsp_entry_flags !== want.entry_flags)
                  report_mismatch("entry_flags", rsp_entry_flags, want.entry_flags);
               if (rsp_entry_port !== want.entry_port)
                  report_mismatch("entry_port", rsp_entry_port, want.entry_port);
            end
            stall_left = quiet ? 0 : $urandom_range(0, 16);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Called right after a rising edge. Valid stays up when the next beat
   // follows with no gap, so it is never dropped and raised in one step.
   task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [SLOT_W-1:0] src,
                            input logic [SLOT_W-1:0] dst, input word_type flags,
                            input word_type port);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         if (valid_held) req_valid <= 1'b0;
         valid_held = 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_slot <= src;
      req_target_slot <= dst;
      req_new_flags <= flags;
      req_new_port <= port;
      do @(posedge clock); while (req_stall);
      expected_outcomes.push_back(table_step(kind, src, dst, flags, port));
      valid_held = 1'b1;
   endtask

   task automatic wait_quiet();
      if (valid_held) req_valid <= 1'b0;
      valid_held = 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_cloexec_mask(input word_type value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cloexec_model = value;
   endtask

   // Mostly open slots, some closed ones, some past the end of the table.
   function automatic logic [SLOT_W-1:0] pick_slot();
      int r, first, i;
      r = $urandom_range(0, 99);
      if (r >= 90) return SLOT_W'($urandom_range(N_SLOTS, (1 << SLOT_W) - 1));
      first = $urandom_range(0, N_SLOTS - 1);
      if (r < 65)
         for (i = 0; i < N_SLOTS; i++)
            if (open_model[(first + i) % N_SLOTS]) return SLOT_W'((first + i) % N_SLOTS);
      return SLOT_W'(first);
   endfunction

   task automatic random_beat(input int alloc_pct);
      logic [KIND_W-1:0] kind;
      word_type flags;
      int r;
      r = $urandom_range(0, 99);
      if (r < alloc_pct) begin
         kind = KIND_ALLOC;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 24) kind = KIND_CLOSE;
         else if (r < 44) kind = KIND_DUP;
         else if (r < 68) kind = KIND_DUP2;
         else if (r < 88) kind = KIND_GET;
         else if (r < 95) kind = KIND_SWEEP;
         else if (r < 98) kind = KIND_CLOSE_ALL;
         else kind = KIND_UNUSED;
      end
      r = $urandom_range(0, 99);
      if (r < 40) flags = $urandom();
      else if (r < 65) flags = $urandom() & ~cloexec_model;
      else if (r < 85) flags = $urandom() | cloexec_model;
      else flags = '0;
      send_beat(kind, pick_slot(), pick_slot(), flags, $urandom());
   endtask

   task automatic test_reset_state();
      send_beat(KIND_GET, 7'd0, '0, '0, '0);
      send_beat(KIND_GET, 7'd1, '0, '0, '0);
      send_beat(KIND_GET, 7'd2, '0, '0, '0);
      send_beat(KIND_GET, 7'd3, '0, '0, '0);
      send_beat(KIND_GET, 7'd127, '0, '0, '0);
      send_beat(KIND_CLOSE, 7'd64, '0, '0, '0);
      send_beat(KIND_DUP2, 7'd1, 7'd1, '0, '0);
      send_beat(KIND_UNUSED, 7'd0, 7'd0, '1, '1);
   endtask

   task automatic test_each_operation();
      send_beat(KIND_ALLOC, '0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(KIND_ALLOC, '0, '0, CLOEXEC_RST, '0);
      send_beat(KIND_GET, 7'd3, '0, '0, '0);
      send_beat(KIND_DUP, 7'd3, '0, '0, '0);
      // open target: close it, lower the hint, then overwrite
      send_beat(KIND_DUP2, 7'd3, 7'd1, '0, '0);
      send_beat(KIND_GET, 7'd1, '0, '0, '0);
      send_beat(KIND_DUP2, 7'd4, 7'd63, '0, '0);
      send_beat(KIND_DUP2, 7'd3, 7'd64, '0, '0);
      send_beat(KIND_DUP2, 7'd3, 7'd127, '0, '0);
      send_beat(KIND_DUP2, 7'd9, 7'd10, '0, '0);
      send_beat(KIND_CLOSE, 7'd4, '0, '0, '0);
      send_beat(KIND_CLOSE, 7'd4, '0, '0, '0);
      send_beat(KIND_ALLOC, '0, '0, 32'h1234_5678, 32'h8765_4321);
      send_beat(KIND_SWEEP, '0, '0, '0, '0);
      send_beat(KIND_CLOSE_ALL, '0, '0, '0, '0);
      send_beat(KIND_GET, 7'd0, '0, '0, '0);
      send_beat(KIND_ALLOC, '0, '0, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
   endtask

   task automatic test_full_table();
      int filled, guard;
      quiet = 1'b1;
      send_beat(KIND_CLOSE_ALL, '0, '0, '0, '0);
      guard = 0;
      forever begin
         filled = 0;
         foreach (open_model[i]) filled += open_model[i];
         if (filled == N_SLOTS || guard == 200) break;
         random_beat(90);
         guard++;
      end
      quiet = 1'b0;
      send_beat(KIND_ALLOC, '0, '0, $urandom(), $urandom());
      send_beat(KIND_DUP, 7'd5, '0, '0, '0);
      repeat (120) random_beat(50);
   endtask

   task automatic test_mask_settings();
      word_type masks [5];
      masks = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0, CLOEXEC_RST};
      masks[3] = $urandom();
      foreach (masks[m]) begin
         wait_quiet();
         write_cloexec_mask(masks[m]);
         for (int n = 0; n < 130; n++) begin
            quiet = (m % 2 == 1) && (n < 40);
            // hold the sender until every result is back
            if (m == 2 && n == 65) wait_quiet();
            random_beat(35);
         end
      end
      quiet = 1'b0;
   endtask

   initial begin
      foreach (open_model[i]) begin
         open_model[i] = (i < 3);
         flags_model[i] = (i == 1 || i == 2) ? 32'd1 : 32'd0;
         ports_model[i] = '0;
      end
      hint_model = 3;
      cloexec_model = CLOEXEC_RST;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_each_operation();
      test_full_table();
      test_mask_settings();
      wait_quiet();
      if (mismatch_count == 0) begin
         $display("PASS descriptor_slot_table");
      end else begin
         $display("FAIL descriptor_slot_table");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL descriptor_slot_table");
      $finish;
   end

endmodule
